[hw/rtl/eaop_pkg.sv]
// ---------------------------------------------------------------------------
// eaop_pkg
// Shared types and constants for the Euler angles to offset point unit.
// ---------------------------------------------------------------------------
package eaop_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int ZW = 33;
  localparam int XW = 34;
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [1:0] {
    CMD_FORWARD = 2'd0,
    CMD_RIGHT   = 2'd1,
    CMD_UP      = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 33'sd536870912;
      1:  r = 33'sd316933406;
      2:  r = 33'sd167458907;
      3:  r = 33'sd85004756;
      4:  r = 33'sd42667331;
      5:  r = 33'sd21354465;
      6:  r = 33'sd10680862;
      7:  r = 33'sd5340245;
      8:  r = 33'sd2670163;
      9:  r = 33'sd1335087;
      10: r = 33'sd667544;
      11: r = 33'sd333772;
      12: r = 33'sd166886;
      13: r = 33'sd83443;
      14: r = 33'sd41722;
      15: r = 33'sd20861;
      16: r = 33'sd10430;
      17: r = 33'sd5215;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + XW'(16384)) >>> 15;
    if (t > XW'(32767)) return 16'sd32767;
    if (t < -XW'(32767)) return -16'sd32767;
    return t[15:0];
  endfunction

endpackage

[hw/rtl/eaop_if.sv]
// ---------------------------------------------------------------------------
// eaop_in_if / eaop_out_if
// Valid/ready channels for requests and result points.
// ---------------------------------------------------------------------------
interface eaop_in_if #(parameter int ANGLE_BITS = 16, parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [ANGLE_BITS-1:0]        yaw_angle;
  logic [ANGLE_BITS-1:0]        pitch_angle;
  logic [ANGLE_BITS-1:0]        roll_angle;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] scale;
  modport source (output valid, command, yaw_angle, pitch_angle, roll_angle,
                  origin_x, origin_y, origin_z, scale, input ready);
  modport sink (input valid, command, yaw_angle, pitch_angle, roll_angle,
                origin_x, origin_y, origin_z, scale, output ready);
endinterface

interface eaop_out_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

[hw/rtl/euler_angles_to_offset_point_unit.sv]
// ---------------------------------------------------------------------------
// euler_angles_to_offset_point_unit
// Offset point along the forward, right or up vector of yaw/pitch/roll angles.
// ---------------------------------------------------------------------------
// One request per clock while out is not stalled, fully pipelined: 18 CORDIC
// cells in a row (one rotation step per cell, three angles side by side) then
// five tail stages. The pipeline advances whenever the output register is
// empty or being taken; a stall on out holds every stage.
module euler_angles_to_offset_point_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  eaop_in_if.sink    in_ch,
  eaop_out_if.source out_ch
);
  import eaop_pkg::*;

  localparam int LAT = CORDIC_STEPS + 5;

  logic adv;
  logic [LAT-1:0] vld_r;
  logic [1:0] cmd_pipe_r [CORDIC_STEPS];
  logic signed [COORD_BITS-1:0] org_pipe_r [CORDIC_STEPS][3];
  logic signed [COORD_BITS-1:0] scl_pipe_r [CORDIC_STEPS];

  assign adv = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  rot_t seed [3];
  rot_t chain [CORDIC_STEPS+1][3];
  logic [ANGLE_BITS-1:0] ang [3];
  assign ang[0] = in_ch.yaw_angle;
  assign ang[1] = in_ch.pitch_angle;
  assign ang[2] = in_ch.roll_angle;

  always_comb begin
    logic [31:0] a;
    for (int k = 0; k < 3; k++) begin
      a = 32'(ang[k]) << (32 - ANGLE_BITS);
      seed[k].quad = a[31:30];
      seed[k].z = ZW'({2'b00, a[29:0]});
      seed[k].x = CORDIC_GAIN_Q30;
      seed[k].y = '0;
    end
  end

  assign chain[0] = seed;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    eaop_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(adv), .rot_in(chain[i]), .rot_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_pipe_r[0] <= in_ch.command;
      org_pipe_r[0][0] <= in_ch.origin_x;
      org_pipe_r[0][1] <= in_ch.origin_y;
      org_pipe_r[0][2] <= in_ch.origin_z;
      scl_pipe_r[0] <= in_ch.scale;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        cmd_pipe_r[i] <= cmd_pipe_r[i-1];
        org_pipe_r[i] <= org_pipe_r[i-1];
        scl_pipe_r[i] <= scl_pipe_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  logic signed [COORD_BITS-1:0] pt [3];

  eaop_vector_tail #(.COORD_BITS(COORD_BITS)) u_tail (
    .clk(clk), .en(adv), .rot_in(chain[CORDIC_STEPS]),
    .cmd_in(cmd_pipe_r[CORDIC_STEPS-1]), .org_in(org_pipe_r[CORDIC_STEPS-1]),
    .scl_in(scl_pipe_r[CORDIC_STEPS-1]), .pt_out(pt)
  );

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.point_x = pt[0];
  assign out_ch.point_y = pt[1];
  assign out_ch.point_z = pt[2];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.point_x))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("stalled with empty output");
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("request lost");
endmodule

[hw/rtl/eaop_cordic_cell.sv]
// ---------------------------------------------------------------------------
// eaop_cordic_cell
// One CORDIC rotation step for three angles, registered on advance.
// ---------------------------------------------------------------------------
module eaop_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  eaop_pkg::rot_t  rot_in [3],
  output eaop_pkg::rot_t  rot_out [3]
);
  import eaop_pkg::*;

  rot_t rot_r [3];
  rot_t rot_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot_nxt[k].quad = rot_in[k].quad;
      if (!rot_in[k].z[ZW-1]) begin
        rot_nxt[k].x = rot_in[k].x - (rot_in[k].y >>> STEP);
        rot_nxt[k].y = rot_in[k].y + (rot_in[k].x >>> STEP);
        rot_nxt[k].z = rot_in[k].z - atan_turn(STEP);
      end else begin
        rot_nxt[k].x = rot_in[k].x + (rot_in[k].y >>> STEP);
        rot_nxt[k].y = rot_in[k].y - (rot_in[k].x >>> STEP);
        rot_nxt[k].z = rot_in[k].z + atan_turn(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot_out = rot_r;
endmodule

[hw/rtl/eaop_vector_tail.sv]
// ---------------------------------------------------------------------------
// eaop_vector_tail
// Builds the basis vector, scales it, adds the origin and saturates.
// ---------------------------------------------------------------------------
module eaop_vector_tail #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  eaop_pkg::rot_t               rot_in [3],
  input  logic [1:0]                   cmd_in,
  input  logic signed [COORD_BITS-1:0] org_in [3],
  input  logic signed [COORD_BITS-1:0] scl_in,
  output logic signed [COORD_BITS-1:0] pt_out [3]
);
  import eaop_pkg::*;

  localparam int PW = COORD_BITS + 34;

  // stage a: quadrant fold
  logic signed [15:0] sn_nxt [3], cs_nxt [3];
  logic signed [15:0] sn_r [3], cs_r [3];
  logic [1:0] cmd_a_r;
  logic signed [COORD_BITS-1:0] org_a_r [3];
  logic signed [COORD_BITS-1:0] scl_a_r;

  always_comb begin
    logic signed [15:0] s, c;
    for (int k = 0; k < 3; k++) begin
      s = clamp_q15(rot_in[k].y);
      c = clamp_q15(rot_in[k].x);
      case (rot_in[k].quad)
        2'd0: begin sn_nxt[k] = s;  cs_nxt[k] = c;  end
        2'd1: begin sn_nxt[k] = c;  cs_nxt[k] = -s; end
        2'd2: begin sn_nxt[k] = -s; cs_nxt[k] = -c; end
        default: begin sn_nxt[k] = -c; cs_nxt[k] = s; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= sn_nxt;
      cs_r <= cs_nxt;
      cmd_a_r <= cmd_in;
      org_a_r <= org_in;
      scl_a_r <= scl_in;
    end
  end

  // stage b: pair products (index 0 yaw, 1 pitch, 2 roll)
  logic signed [31:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r, pg_r, ph_r, pi_r;
  logic signed [15:0] sp_b_r, sr_b_r, cr_b_r;
  logic [1:0] cmd_b_r;
  logic signed [COORD_BITS-1:0] org_b_r [3];
  logic signed [COORD_BITS-1:0] scl_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= cs_r[1] * cs_r[0];
      pb_r <= cs_r[1] * sn_r[0];
      pc_r <= sn_r[1] * cs_r[0];
      pd_r <= sn_r[1] * sn_r[0];
      pe_r <= cs_r[2] * sn_r[0];
      pf_r <= cs_r[2] * cs_r[0];
      pg_r <= sn_r[2] * sn_r[0];
      ph_r <= sn_r[2] * cs_r[0];
      pi_r <= 32'(cs_r[1]);
      sp_b_r <= sn_r[1];
      sr_b_r <= sn_r[2];
      cr_b_r <= cs_r[2];
      cmd_b_r <= cmd_a_r;
      org_b_r <= org_a_r;
      scl_b_r <= scl_a_r;
    end
  end

  // stage c: vector at 45 fraction bits, rounded to 30
  logic signed [48:0] v45 [3];
  logic signed [33:0] v30_r [3];
  logic signed [COORD_BITS-1:0] org_c_r [3];
  logic signed [COORD_BITS-1:0] scl_c_r;

  always_comb begin
    logic signed [48:0] k15_pa, k15_pb, k15_pe, k15_pf, k15_g, k15_h;
    k15_pa = 49'(pa_r) <<< 15;
    k15_pb = 49'(pb_r) <<< 15;
    k15_pe = 49'(pe_r) <<< 15;
    k15_pf = 49'(pf_r) <<< 15;
    k15_g  = 49'(pg_r) <<< 15;
    k15_h  = 49'(ph_r) <<< 15;
    v45[0] = '0; v45[1] = '0; v45[2] = '0;
    case (cmd_b_r)
      CMD_FORWARD: begin
        v45[0] = k15_pa;
        v45[1] = k15_pb;
        v45[2] = -(49'(sp_b_r) <<< 30);
      end
      CMD_RIGHT: begin
        v45[0] = -(49'(sr_b_r) * 49'(pc_r)) + k15_pe;
        v45[1] = -(49'(sr_b_r) * 49'(pd_r)) - k15_pf;
        v45[2] = -((49'(sr_b_r) * 49'(pi_r)) <<< 15);
      end
      CMD_UP: begin
        v45[0] = 49'(cr_b_r) * 49'(pc_r) + k15_g;
        v45[1] = 49'(cr_b_r) * 49'(pd_r) - k15_h;
        v45[2] = (49'(cr_b_r) * 49'(pi_r)) <<< 15;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        v30_r[j] <= 34'((v45[j] + 49'sd16384) >>> 15);
      end
      org_c_r <= org_b_r;
      scl_c_r <= scl_b_r;
    end
  end

  // stage d: magnitude multiply
  logic [PW-1:0] mag_r [3];
  logic neg_r [3];
  logic signed [COORD_BITS-1:0] org_d_r [3];
  logic [COORD_BITS-1:0] ub;

  assign ub = scl_c_r[COORD_BITS-1] ? COORD_BITS'(-scl_c_r) : COORD_BITS'(scl_c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag_r[j] <= PW'(v30_r[j][33] ? 34'(-v30_r[j]) : v30_r[j]) * PW'(ub);
        neg_r[j] <= v30_r[j][33] ^ scl_c_r[COORD_BITS-1];
      end
      org_d_r <= org_c_r;
    end
  end

  // stage e: round, add origin, saturate
  logic signed [COORD_BITS-1:0] pt_r [3];
  localparam logic signed [PW-1:0] LIM_HI = PW'((64'sd1 <<< (COORD_BITS-1)) - 1);
  localparam logic signed [PW-1:0] LIM_LO = -PW'(64'sd1 <<< (COORD_BITS-1));

  always_ff @(posedge clk) begin
    logic [PW-1:0] m;
    logic signed [PW-1:0] sum;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        m = (mag_r[j] + PW'(64'd1 << 29)) >> 30;
        sum = (neg_r[j] ? -$signed(m) : $signed(m)) + PW'(org_d_r[j]);
        if (sum > LIM_HI) pt_r[j] <= LIM_HI[COORD_BITS-1:0];
        else if (sum < LIM_LO) pt_r[j] <= LIM_LO[COORD_BITS-1:0];
        else pt_r[j] <= sum[COORD_BITS-1:0];
      end
    end
  end

  assign pt_out = pt_r;
endmodule
